// ===== sv/mcp_pkg.sv =====
package mcp_pkg;

  // Column store geometry
  localparam int MAX_COLUMNS     = 8;
  localparam int COL_W           = $clog2(MAX_COLUMNS);
  localparam int COUNT_W         = COL_W + 1;
  localparam int DEFAULT_COLUMNS = 3;

  // Field widths
  localparam int HEIGHT_W  = 32;
  localparam int ITEM_H_W  = 15;
  localparam int COORD_W   = 16;
  localparam int AREA_W_W  = 15;
  localparam int GAP_W     = 10;
  localparam int CCOUNT_W  = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Radix-4 divider: two quotient bits per step over a 16-bit dividend
  localparam int DIV_DVD_W = 16;
  localparam int DIV_STEPS = DIV_DVD_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic signed [HEIGHT_W+1:0] HEIGHT_MAX = 34'sh0_7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_FIN
  } mcp_state_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COLUMN_COUNT = 3'd0,
    REG_AREA_LEFT    = 3'd1,
    REG_AREA_TOP     = 3'd2,
    REG_AREA_WIDTH   = 3'd3,
    REG_GAP          = 3'd4
  } mcp_reg_t;

endpackage

// ===== sv/mcp_item_if.sv =====
interface mcp_item_if import mcp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ITEM_H_W-1:0] item_height;
  logic                start_pass;

  modport source (output valid, output item_height, output start_pass, input ready);
  modport sink   (input valid, input item_height, input start_pass, output ready);
endinterface

// ===== sv/mcp_result_if.sv =====
interface mcp_result_if import mcp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] pos_x;
  logic signed [HEIGHT_W-1:0] pos_y;
  logic [AREA_W_W-1:0]        box_width;
  logic [ITEM_H_W-1:0]        box_height;
  logic [COL_W-1:0]           column_index;

  modport source (output valid, output pos_x, output pos_y, output box_width,
                  output box_height, output column_index, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input box_width,
                  input box_height, input column_index, output ready);
endinterface

// ===== sv/mcp_cfg_if.sv =====
interface mcp_cfg_if import mcp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/masonry_column_placer.sv =====
// Channel      Dir  Payload                                           Accept
// item_in      in   item_height[15], start_pass                       valid & ready
// result_out   out  pos_x[32], pos_y[32], box_width[15],
//                   box_height[15], column_index[3]                   valid & ready
// cfg          in   addr[3] (register index), data[16]                valid & ready
//
// Steps: accept, scan (n height reads and a compare, overlapped with the 8-step
// width divider), multiply, write-back; item_in is ready only in the idle state,
// so a new item is taken only once the last one has been written back.
// Reset (rst, synchronous) clears the control state and the column valid bits; a
// column without its valid bit reads as the latched pass top. A waiting result
// stalls the next item in write-back until the output register is free.
module masonry_column_placer import mcp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mcp_item_if.sink    item_in,
  mcp_result_if.source result_out,
  mcp_cfg_if.sink     cfg
);

  // Configuration registers
  logic [CCOUNT_W-1:0]       column_count;
  logic signed [COORD_W-1:0] area_left;
  logic signed [COORD_W-1:0] area_top;
  logic [AREA_W_W-1:0]       area_width;
  logic [GAP_W-1:0]          gap;

  // Item registers, latched at accept
  logic [ITEM_H_W-1:0]       h_q;
  logic [COUNT_W-1:0]        n_q;
  logic signed [COORD_W-1:0] left_q;
  logic [GAP_W-1:0]          gap_q;
  logic [AREA_W_W-1:0]       width_q;
  logic signed [HEIGHT_W-1:0] pass_top;

  // Height memory with one valid bit per column
  logic [HEIGHT_W-1:0]    col_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] col_valid;

  // Scan pipeline
  logic [COUNT_W-1:0]         rd_idx;
  logic                       rd_en;
  logic                       rd_pend;
  logic                       rd_first;
  logic                       rd_hit;
  logic [COL_W-1:0]           rd_col;
  logic [HEIGHT_W-1:0]        rd_data;
  logic signed [HEIGHT_W-1:0] cand;
  logic signed [HEIGHT_W-1:0] best_val;
  logic [COL_W-1:0]           best;
  logic                       scan_done;

  // Divider
  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DVD_W-1:0] quo;
  logic [COUNT_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_done;
  logic [COUNT_W:0]     dv_r1;
  logic [COUNT_W:0]     dv_r2;
  logic [COUNT_W-1:0]   dv_m1;
  logic [COUNT_W-1:0]   dv_m2;
  logic                 dv_b1;
  logic                 dv_b2;

  // Placement math
  logic [AREA_W_W+COL_W-1:0]  prod;
  logic signed [HEIGHT_W+1:0] sum;
  logic signed [HEIGHT_W-1:0] grown;
  logic signed [HEIGHT_W-1:0] pos_x_q;

  // Control
  mcp_state_t state, state_next;
  logic       item_acc;
  logic       fin_go;
  logic       out_valid;
  logic [COUNT_W-1:0] n_sel;

  // Columns in use: zero means the default, clamp to the store depth
  always_comb begin
    if (column_count == '0) begin
      n_sel = COUNT_W'(DEFAULT_COLUMNS);
    end else if (column_count > CCOUNT_W'(MAX_COLUMNS)) begin
      n_sel = COUNT_W'(MAX_COLUMNS);
    end else begin
      n_sel = COUNT_W'(column_count);
    end
  end

  // Configuration writes, taken every cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CCOUNT_W'(DEFAULT_COLUMNS);
      area_left    <= '0;
      area_top     <= '0;
      area_width   <= '0;
      gap          <= '0;
    end else if (cfg.valid) begin
      case (mcp_reg_t'(cfg.addr))
        REG_COLUMN_COUNT: column_count <= cfg.data[CCOUNT_W-1:0];
        REG_AREA_LEFT:    area_left    <= cfg.data[COORD_W-1:0];
        REG_AREA_TOP:     area_top     <= cfg.data[COORD_W-1:0];
        REG_AREA_WIDTH:   area_width   <= cfg.data[AREA_W_W-1:0];
        REG_GAP:          gap          <= cfg.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_acc = item_in.valid && item_in.ready;

  // Latch the item and its configuration snapshot
  always_ff @(posedge clk) begin
    if (item_acc) begin
      h_q     <= item_in.item_height;
      n_q     <= n_sel;
      left_q  <= area_left;
      gap_q   <= gap;
      width_q <= area_width;
    end
  end

  // A new pass drops every stored height back to the area top
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
      pass_top  <= '0;
    end else if (item_acc && item_in.start_pass) begin
      col_valid <= '0;
      pass_top  <= HEIGHT_W'(area_top);
    end else if (state == ST_FIN && fin_go) begin
      col_valid[best] <= 1'b1;
    end
  end

  // Read one column per cycle during the scan
  assign rd_en = (state == ST_SCAN) && (rd_idx < n_q);

  always_ff @(posedge clk) begin
    if (item_acc) begin
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= col_mem[rd_idx[COL_W-1:0]];
    end
    if (state == ST_FIN && fin_go) begin
      col_mem[best] <= grown;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit   <= col_valid[rd_idx[COL_W-1:0]];
      rd_col   <= rd_idx[COL_W-1:0];
      rd_first <= (rd_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  // Keep the strictly smaller height so ties stay on the lowest column
  assign cand = rd_hit ? $signed(rd_data) : pass_top;

  always_ff @(posedge clk) begin
    if (rd_pend && (rd_first || cand < best_val)) begin
      best_val <= cand;
      best     <= rd_col;
    end
  end

  assign scan_done = (rd_idx == n_q) && !rd_pend;

  // Column width: restoring divide, two quotient bits per cycle
  always_comb begin
    dv_r1 = {rem, dvd[DIV_DVD_W-1]};
    dv_b1 = dv_r1 >= {1'b0, n_q};
    dv_m1 = dv_b1 ? COUNT_W'(dv_r1 - {1'b0, n_q}) : COUNT_W'(dv_r1);
    dv_r2 = {dv_m1, dvd[DIV_DVD_W-2]};
    dv_b2 = dv_r2 >= {1'b0, n_q};
    dv_m2 = dv_b2 ? COUNT_W'(dv_r2 - {1'b0, n_q}) : COUNT_W'(dv_r2);
  end

  assign div_done = (div_cnt == DIV_CNT_W'(DIV_STEPS));

  always_ff @(posedge clk) begin
    if (item_acc) begin
      dvd     <= {1'b0, area_width};
      quo     <= '0;
      rem     <= '0;
      div_cnt <= '0;
    end else if (state == ST_SCAN && !div_done) begin
      dvd     <= {dvd[DIV_DVD_W-3:0], 2'b00};
      quo     <= {quo[DIV_DVD_W-3:0], dv_b1, dv_b2};
      rem     <= dv_m2;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // x offset and grown height
  assign prod = {{AREA_W_W{1'b0}}, best} * {{COL_W{1'b0}}, quo[AREA_W_W-1:0]};
  assign sum  = (HEIGHT_W+2)'(best_val) + $signed({{(HEIGHT_W+2-ITEM_H_W){1'b0}}, h_q})
              + $signed({{(HEIGHT_W+2-GAP_W){1'b0}}, gap_q});

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      pos_x_q <= HEIGHT_W'(left_q) + $signed({{(HEIGHT_W-AREA_W_W-COL_W){1'b0}}, prod});
      grown   <= (sum > HEIGHT_MAX) ? HEIGHT_MAX[HEIGHT_W-1:0] : sum[HEIGHT_W-1:0];
    end
  end

  // State machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_acc) state_next = ST_SCAN;
      ST_SCAN: if (scan_done && div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_FIN;
      ST_FIN:  if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_in.ready = (state == ST_IDLE);
    fin_go        = !out_valid || result_out.ready;
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && fin_go) begin
      result_out.pos_x        <= pos_x_q;
      result_out.pos_y        <= best_val;
      result_out.box_width    <= quo[AREA_W_W-1:0];
      result_out.box_height   <= h_q;
      result_out.column_index <= best;
    end
  end

  assign result_out.valid = out_valid;

`ifndef SYNTH
  // Width times column count never exceeds the area width
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |->
      ({{COUNT_W{1'b0}}, quo[AREA_W_W-1:0]} * {{AREA_W_W{1'b0}}, n_q})
        <= {{COUNT_W{1'b0}}, width_q})
    else $error("column width exceeds area share");

  // A placed column only grows
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (grown >= best_val))
    else $error("column height shrank");

  // Write-back marks the chosen column as holding a stored height
  a_wb_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && fin_go) |=> col_valid[$past(best)])
    else $error("written column not marked valid");

  // The chosen column lies within the columns in use
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ({1'b0, best} < n_q))
    else $error("chosen column outside columns in use");
`endif

endmodule
